FILE: rtl/teh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_pkg: shared types and constants of the timer expiry queue
// Entry layout, request kinds, result codes and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package teh_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;
   localparam int ENTRY_W = TIME_W + ID_W;

   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_CHECK  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_NONE_DUE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   id;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic move_rd;
      logic move_wr;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic due;
      logic out_free;
   } sts_type;

   // strict ordering: earlier expiry first, ties to the smaller id
   function automatic logic entry_before(entry_type a, entry_type b);
      if (a.expiry != b.expiry) begin
         return a.expiry < b.expiry;
      end
      return a.id < b.id;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/teh_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_req_if: request channel
// Valid/ready channel carrying one timer request.
// ----------------------------------------------------------------------------
interface teh_req_if import teh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] interval;
   logic [ID_W-1:0]   cancel_id;

   modport source (output valid, kind, now, interval, cancel_id, input ready);
   modport sink   (input valid, kind, now, interval, cancel_id, output ready);
endinterface
`default_nettype wire

FILE: rtl/teh_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_rsp_if: response channel
// Valid/ready channel carrying one timer result.
// ----------------------------------------------------------------------------
interface teh_rsp_if import teh_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      status;
   logic [ID_W-1:0] tmr_id;
   logic            fired;

   modport source (output valid, status, tmr_id, fired, input ready);
   modport sink   (input valid, status, tmr_id, fired, output ready);
endinterface
`default_nettype wire

FILE: rtl/teh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module teh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/teh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_ctrl: request sequencer
// State machine that steps the datapath through start, cancel and check.
// ----------------------------------------------------------------------------
module teh_ctrl import teh_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_kind,
   output logic            req_ready,
   input  wire sts_type    sts,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MOVE_RD,
      S_MOVE_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               kind_in      = kind_type'(req_kind);
               unique case (kind_type'(req_kind))
                  KIND_START:  state_in = S_RESP;
                  KIND_CANCEL,
                  KIND_CHECK:  state_in = S_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (kind_ff == KIND_CHECK && sts.due) begin
                  state_in = S_MOVE_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_MOVE_RD: begin
            cmd.move_rd = 1'b1;
            state_in    = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= KIND_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/teh_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// teh_dpath: timer store and result datapath
// Entry RAM, fill count, id counter, scan unit and result register.
// ----------------------------------------------------------------------------
module teh_dpath import teh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output sts_type                sts,
   input  wire logic [1:0]        req_kind,
   input  wire logic [TIME_W-1:0] req_now,
   input  wire logic [TIME_W-1:0] req_interval,
   input  wire logic [ID_W-1:0]   req_cancel_id,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [ID_W-1:0]        rsp_tmr_id,
   output logic                   rsp_fired
);

   kind_type          kind_ff;
   logic [TIME_W-1:0] now_ff, interval_ff;
   logic [ID_W-1:0]   cid_ff;
   logic [CNT_W-1:0]  count_ff, idx_ff, wptr_ff;
   logic [ID_W-1:0]   next_id_ff;
   logic              rd_pend_ff;
   logic [ADDR_W-1:0] rd_idx_ff;
   logic              best_vld_ff, hit_ff;
   entry_type         best_ff;
   logic [ADDR_W-1:0] best_idx_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_fired_ff;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_data, rd_data;
   logic [TIME_W:0]   sum;
   logic [TIME_W-1:0] expiry_new;
   logic              full, scan_issue, keep, take;
   logic [CNT_W-1:0]  last;

   assign sum        = {1'b0, now_ff} + {1'b0, interval_ff};
   assign expiry_new = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign last       = count_ff - CNT_W'(1);
   assign scan_issue = cmd.scan_step && (idx_ff < count_ff);
   assign keep       = rd_pend_ff && kind_ff == KIND_CANCEL && rd_data.id != cid_ff;
   assign take       = rd_pend_ff && kind_ff == KIND_CHECK
                       && (!best_vld_ff || entry_before(rd_data, best_ff));

   always_comb begin
      rd_en   = scan_issue || cmd.move_rd;
      rd_addr = cmd.move_rd ? last[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = rd_data;
      priority if (keep) begin
         wr_en   = 1'b1;
         wr_addr = wptr_ff[ADDR_W-1:0];
      end else if (cmd.move_wr) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
      end else if (cmd.rsp_load && kind_ff == KIND_START && !full) begin
         wr_en   = 1'b1;
         wr_data = '{expiry: expiry_new, id: next_id_ff};
      end else begin
         wr_en   = 1'b0;
      end
   end

   teh_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign sts.scan_done = (idx_ff == count_ff) && !rd_pend_ff;
   assign sts.due       = best_vld_ff && (best_ff.expiry <= now_ff);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // request latch and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff     <= kind_type'(req_kind);
         now_ff      <= req_now;
         interval_ff <= req_interval;
         cid_ff      <= req_cancel_id;
      end
      if (scan_issue) begin
         rd_idx_ff <= idx_ff[ADDR_W-1:0];
      end
      if (take) begin
         best_ff     <= rd_data;
         best_idx_ff <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_id_ff   <= ID_W'(1);
         idx_ff       <= '0;
         wptr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= scan_issue;
         if (cmd.load_req) begin
            idx_ff      <= '0;
            wptr_ff     <= '0;
            best_vld_ff <= 1'b0;
            hit_ff      <= 1'b0;
         end
         if (scan_issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (keep) begin
            wptr_ff <= wptr_ff + CNT_W'(1);
         end
         if (take) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.move_wr) begin
            count_ff <= last;
            hit_ff   <= 1'b1;
         end
         if (rsp_valid_ff && rsp_ready && !cmd.rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (kind_ff == KIND_START && !full) begin
               count_ff   <= count_ff + CNT_W'(1);
               next_id_ff <= next_id_ff + ID_W'(1);
            end else if (kind_ff == KIND_CANCEL) begin
               count_ff <= wptr_ff;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         unique case (kind_ff)
            KIND_START: begin
               rsp_status_ff <= full ? ST_FULL : ST_OK;
               rsp_id_ff     <= full ? '0 : next_id_ff;
               rsp_fired_ff  <= 1'b0;
            end
            KIND_CANCEL: begin
               rsp_status_ff <= (wptr_ff == count_ff) ? ST_NOT_FOUND : ST_OK;
               rsp_id_ff     <= cid_ff;
               rsp_fired_ff  <= 1'b0;
            end
            default: begin
               rsp_status_ff <= hit_ff ? ST_OK : ST_NONE_DUE;
               rsp_id_ff     <= hit_ff ? best_ff.id : '0;
               rsp_fired_ff  <= hit_ff;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tmr_id = rsp_id_ff;
   assign rsp_fired  = rsp_fired_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_wptr_behind: assert property (@(posedge clock) disable iff (reset)
      wptr_ff <= idx_ff)
      else $error("compaction pointer ahead of scan");

   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.move_wr |-> (count_ff != '0) && hit_ff == 1'b0 && best_vld_ff)
      else $error("move without a due entry");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

endmodule
`default_nettype wire

FILE: rtl/timer_expiry_heap_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timer_expiry_heap_unit: timer queue ordered by expiry
// Holds up to DEPTH timers; start, cancel and check requests, one result each.
// ----------------------------------------------------------------------------
// req_bus: one transfer per request; rsp_bus: one transfer per start, cancel
//   or check; kind 3 is taken and dropped without a result
// start stores now + interval (saturating) under a fresh id, cancel removes
//   every entry with the id, check pops the earliest entry (ties to the
//   smaller id) if its expiry is not after now
// steps, request transfer to result valid: start goes straight to the
//   result; cancel and check scan the stored timers, a popping check then
//   moves the last entry into the freed slot (read, then write); the scan
//   goes through the single ram read port: every stored entry is read once
// throughput: one request at a time; the next one is taken the cycle after
//   the result is loaded, even while that result stalls
// receiver stall: the result register holds; the following request then
//   waits for it and req_bus.ready stays low meanwhile
// reset: synchronous; entry count to zero, id counter to one, ram not
//   cleared (only filled entries are ever read)
// ----------------------------------------------------------------------------
module timer_expiry_heap_unit import teh_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   teh_req_if.sink  req_bus,
   teh_rsp_if.source rsp_bus
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: accepts requests and walks the datapath through them
   teh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // entry store, scan and result register
   teh_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_kind      (req_bus.kind),
      .req_now       (req_bus.now),
      .req_interval  (req_bus.interval),
      .req_cancel_id (req_bus.cancel_id),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_status    (rsp_bus.status),
      .rsp_tmr_id    (rsp_bus.tmr_id),
      .rsp_fired     (rsp_bus.fired)
   );

endmodule
`default_nettype wire
